[hw/rtl/cfpa_pkg.sv]
package cfpa_pkg;

    // Operand format and CORDIC depth
    localparam int DW       = 16;
    localparam int FW       = 11;
    localparam int STEPS    = 16;
    localparam int GUARD    = 16;
    localparam int ANG_FRAC = 30;

    // Internal widths
    localparam int XW    = DW + GUARD + 3;        // CORDIC x, y, z
    localparam int PW    = 2 * DW;                // one product
    localparam int SW    = 2 * DW + 1;            // sum of two products
    localparam int DNW   = 2 * DW;                // |b|^2
    localparam int IBITS = DW - FW;               // quotient bits above the point
    localparam int QW    = DW + 1;                // quotient bits incl. rounding bit
    localparam int RW    = DNW + IBITS;           // partial remainder
    localparam int MAGW  = 24;                    // magnitude before saturation
    localparam int NCELL = (STEPS > QW) ? STEPS : QW;

    // Stream word widths
    localparam int IN_TW  = 72;
    localparam int OUT_TW = 40;

    localparam logic signed [XW-1:0] PI_Z      = 35'sd3373259426;
    localparam logic [29:0]          INV_GAIN  = 30'd652032874;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001, 30'h00000000
    };

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_MUL   = 3'd2,
        FN_DIV   = 3'd3,
        FN_CONJ  = 3'd4,
        FN_NORM  = 3'd5,
        FN_PHASE = 3'd6
    } func_t;

    // Payload handed from cell to cell
    typedef struct packed {
        func_t                 func;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [XW-1:0]  z;
        logic [DNW-1:0]        dn;
        logic [RW-1:0]         r_re;
        logic [RW-1:0]         r_im;
        logic [QW-1:0]         q_re;
        logic [QW-1:0]         q_im;
        logic                  neg_re;
        logic                  neg_im;
        logic                  big_re;
        logic                  big_im;
        logic                  a_zero;
        logic                  dz;
        logic signed [DW-1:0]  res_re;
        logic signed [DW-1:0]  res_im;
        logic                  ov;
    } cell_t;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic                 ov;
        logic                 dz;
    } res_t;

    // Saturate a one-bit-grown value; returns {overflow, value}
    function automatic logic [DW:0] clamp_s(input logic signed [DW:0] v);
        logic [DW-1:0] sat;
        sat = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return (v[DW] != v[DW-1]) ? {1'b1, sat} : {1'b0, v[DW-1:0]};
    endfunction

    // Signed result from sign and magnitude; returns {overflow, value}
    function automatic logic [DW:0] from_mag(input logic neg, input logic [MAGW-1:0] mag);
        logic [MAGW-1:0] lim;
        logic [MAGW-1:0] m;
        logic [MAGW-1:0] v;
        logic            ov;
        lim = neg ? (MAGW'(1) << (DW - 1)) : ((MAGW'(1) << (DW - 1)) - MAGW'(1));
        ov  = mag > lim;
        m   = ov ? lim : mag;
        v   = neg ? (MAGW'(0) - m) : m;
        return {ov, v[DW-1:0]};
    endfunction

endpackage

[hw/rtl/cfpa_front.sv]
module cfpa_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  cfpa_pkg::func_t              func,
    input  logic signed [cfpa_pkg::DW-1:0] a_re,
    input  logic signed [cfpa_pkg::DW-1:0] a_im,
    input  logic signed [cfpa_pkg::DW-1:0] b_re,
    input  logic signed [cfpa_pkg::DW-1:0] b_im,
    output logic                         out_valid,
    output cfpa_pkg::cell_t              out_c
);
    import cfpa_pkg::*;

    typedef struct packed {
        func_t                 func;
        logic signed [PW-1:0]  p_rr;
        logic signed [PW-1:0]  p_ii;
        logic signed [PW-1:0]  p_ri;
        logic signed [PW-1:0]  p_ir;
        logic signed [PW-1:0]  p_bbr;
        logic signed [PW-1:0]  p_bbi;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [XW-1:0]  z;
        logic                  a_zero;
        logic                  b_zero;
        logic signed [DW-1:0]  res_re;
        logic signed [DW-1:0]  res_im;
        logic                  ov;
    } front_t;

    function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] s);
        return s[SW-1] ? SW'(-s) : SW'(s);
    endfunction

    front_t a_next, a_reg;
    logic   a_valid_reg;
    cell_t  b_next, b_reg;
    logic   b_valid_reg;

    logic [DW:0]           cr, ci;
    logic signed [XW-1:0]  x0, y0;

    logic signed [SW-1:0]  m_re, m_im, n_re, n_im;
    logic [SW-1:0]         mm_re, mm_im, t_re, t_im, dm_re, dm_im;
    logic [DNW-1:0]        dn;
    logic [DW:0]           fr, fi;

    // Stage A: products, simple operations and CORDIC folding
    always_comb
    begin
        a_next        = '0;
        a_next.func   = func;
        a_next.p_rr   = a_re * b_re;
        a_next.p_ii   = a_im * b_im;
        a_next.p_ri   = a_re * b_im;
        a_next.p_ir   = a_im * b_re;
        a_next.p_bbr  = b_re * b_re;
        a_next.p_bbi  = b_im * b_im;
        a_next.a_zero = (a_re == '0) && (a_im == '0);
        a_next.b_zero = (b_re == '0) && (b_im == '0);

        x0 = {{(XW-DW-GUARD){a_re[DW-1]}}, a_re, {GUARD{1'b0}}};
        y0 = {{(XW-DW-GUARD){a_im[DW-1]}}, a_im, {GUARD{1'b0}}};
        if (a_re[DW-1])
        begin
            a_next.x = -x0;
            a_next.y = -y0;
            a_next.z = a_im[DW-1] ? -PI_Z : PI_Z;
        end
        else
        begin
            a_next.x = x0;
            a_next.y = y0;
            a_next.z = '0;
        end

        cr = '0;
        ci = '0;
        unique case (func)
            FN_ADD:
            begin
                cr = clamp_s((DW+1)'(a_re) + (DW+1)'(b_re));
                ci = clamp_s((DW+1)'(a_im) + (DW+1)'(b_im));
            end
            FN_SUB:
            begin
                cr = clamp_s((DW+1)'(a_re) - (DW+1)'(b_re));
                ci = clamp_s((DW+1)'(a_im) - (DW+1)'(b_im));
            end
            FN_CONJ:
            begin
                cr = {1'b0, a_re};
                ci = clamp_s(-((DW+1)'(a_im)));
            end
            default:
            begin
                cr = '0;
                ci = '0;
            end
        endcase
        a_next.res_re = cr[DW-1:0];
        a_next.res_im = ci[DW-1:0];
        a_next.ov     = cr[DW] | ci[DW];
    end

    // Stage B: product sums, rounding of the product, divider set-up
    always_comb
    begin
        m_re  = SW'(a_reg.p_rr) - SW'(a_reg.p_ii);
        m_im  = SW'(a_reg.p_ri) + SW'(a_reg.p_ir);
        n_re  = SW'(a_reg.p_rr) + SW'(a_reg.p_ii);
        n_im  = SW'(a_reg.p_ir) - SW'(a_reg.p_ri);
        mm_re = mag_of(m_re);
        mm_im = mag_of(m_im);
        t_re  = mm_re + (SW'(1) << (FW - 1));
        t_im  = mm_im + (SW'(1) << (FW - 1));
        fr    = from_mag(m_re[SW-1], MAGW'(t_re >> FW));
        fi    = from_mag(m_im[SW-1], MAGW'(t_im >> FW));
        dm_re = mag_of(n_re);
        dm_im = mag_of(n_im);
        dn    = DNW'($unsigned(a_reg.p_bbr)) + DNW'($unsigned(a_reg.p_bbi));

        b_next        = '0;
        b_next.func   = a_reg.func;
        b_next.x      = a_reg.x;
        b_next.y      = a_reg.y;
        b_next.z      = a_reg.z;
        b_next.dn     = dn;
        b_next.r_re   = RW'(dm_re);
        b_next.r_im   = RW'(dm_im);
        b_next.neg_re = n_re[SW-1];
        b_next.neg_im = n_im[SW-1];
        b_next.big_re = RW'(dm_re) >= {dn, {IBITS{1'b0}}};
        b_next.big_im = RW'(dm_im) >= {dn, {IBITS{1'b0}}};
        b_next.a_zero = a_reg.a_zero;
        b_next.dz     = a_reg.b_zero;
        if (a_reg.func == FN_MUL)
        begin
            b_next.res_re = fr[DW-1:0];
            b_next.res_im = fi[DW-1:0];
            b_next.ov     = fr[DW] | fi[DW];
        end
        else
        begin
            b_next.res_re = a_reg.res_re;
            b_next.res_im = a_reg.res_im;
            b_next.ov     = a_reg.ov;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_c     = b_reg;

endmodule

[hw/rtl/cfpa_cell.sv]
module cfpa_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cfpa_pkg::cell_t in_c,
    output logic            out_valid,
    output cfpa_pkg::cell_t out_c
);
    import cfpa_pkg::*;

    cell_t                 c_next, c_reg;
    logic                  valid_reg;
    logic signed [XW-1:0]  xs, ys, ang;
    logic [RW-1:0]         ds, tr, ti;
    logic                  ge_re, ge_im;

    // One quotient bit per part; rotation while IDX < STEPS
    always_comb
    begin
        c_next = in_c;
        xs     = in_c.x >>> IDX;
        ys     = in_c.y >>> IDX;
        ang    = XW'(ATAN_Q30[IDX % 32]);
        if (IDX < STEPS)
        begin
            if (!in_c.y[XW-1])
            begin
                c_next.x = in_c.x + ys;
                c_next.y = in_c.y - xs;
                c_next.z = in_c.z + ang;
            end
            else
            begin
                c_next.x = in_c.x - ys;
                c_next.y = in_c.y + xs;
                c_next.z = in_c.z - ang;
            end
        end

        ds    = RW'({in_c.dn, {(IBITS-1){1'b0}}});
        ge_re = in_c.r_re >= ds;
        ge_im = in_c.r_im >= ds;
        tr    = ge_re ? (in_c.r_re - ds) : in_c.r_re;
        ti    = ge_im ? (in_c.r_im - ds) : in_c.r_im;
        c_next.r_re = {tr[RW-2:0], 1'b0};
        c_next.r_im = {ti[RW-2:0], 1'b0};
        c_next.q_re = {in_c.q_re[QW-2:0], ge_re};
        c_next.q_im = {in_c.q_im[QW-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= c_next;
    end

    assign out_valid = valid_reg;
    assign out_c     = c_reg;

endmodule

[hw/rtl/cfpa_back.sv]
module cfpa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cfpa_pkg::cell_t in_c,
    output logic            out_valid,
    output cfpa_pkg::res_t  out_r
);
    import cfpa_pkg::*;

    localparam int XLW    = GUARD + 1;
    localparam int PRW    = XLW + 30;
    localparam int SUMW   = PRW + XLW;
    localparam int NRM_SH = ANG_FRAC + GUARD;
    localparam int PH_SH  = ANG_FRAC - FW;

    typedef struct packed {
        func_t                 func;
        res_t                  r;
        logic [PRW-1:0]        ph;
        logic [PRW-1:0]        pl;
    } back_t;

    back_t                 c_next, c_reg;
    logic                  valid_reg;
    logic [QW:0]           qr, qi;
    logic [DW:0]           dr, di, fp, fn;
    logic [XW-1:0]         zmag, zt;
    logic [SUMW-1:0]       sum;

    // Stage C: quotient rounding, phase rounding, norm partial products
    always_comb
    begin
        qr   = ({1'b0, in_c.q_re} + (QW+1)'(1)) >> 1;
        qi   = ({1'b0, in_c.q_im} + (QW+1)'(1)) >> 1;
        dr   = from_mag(in_c.neg_re, in_c.big_re ? '1 : MAGW'(qr));
        di   = from_mag(in_c.neg_im, in_c.big_im ? '1 : MAGW'(qi));
        zmag = in_c.z[XW-1] ? XW'(-in_c.z) : XW'(in_c.z);
        zt   = zmag + (XW'(1) << (PH_SH - 1));
        fp   = from_mag(in_c.z[XW-1], MAGW'(zt >> PH_SH));

        c_next      = '0;
        c_next.func = in_c.func;
        c_next.ph   = PRW'(in_c.x[XW-2:XLW]) * PRW'(INV_GAIN);
        c_next.pl   = PRW'(in_c.x[XLW-1:0]) * PRW'(INV_GAIN);
        unique case (in_c.func)
            FN_DIV:
            begin
                if (in_c.dz)
                    c_next.r.dz = 1'b1;
                else
                begin
                    c_next.r.res_re = dr[DW-1:0];
                    c_next.r.res_im = di[DW-1:0];
                    c_next.r.ov     = dr[DW] | di[DW];
                end
            end
            FN_PHASE:
            begin
                if (!in_c.a_zero)
                begin
                    c_next.r.res_re = fp[DW-1:0];
                    c_next.r.ov     = fp[DW];
                end
            end
            FN_NORM:
            begin
                c_next.r = '0;
            end
            default:
            begin
                c_next.r.res_re = in_c.res_re;
                c_next.r.res_im = in_c.res_im;
                c_next.r.ov     = in_c.ov;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= c_next;
    end

    // Stage D: combine the norm products and pick the result
    always_comb
    begin
        sum = {c_reg.ph, {XLW{1'b0}}} + SUMW'(c_reg.pl) + (SUMW'(1) << (NRM_SH - 1));
        fn  = from_mag(1'b0, MAGW'(sum >> NRM_SH));
        out_r = c_reg.r;
        if (c_reg.func == FN_NORM)
        begin
            out_r.res_re = fn[DW-1:0];
            out_r.res_im = '0;
            out_r.ov     = fn[DW];
            out_r.dz     = 1'b0;
        end
    end

    assign out_valid = valid_reg;

endmodule

[hw/rtl/complex_fixed_point_alu.sv]
// Complex fixed-point ALU: add, sub, mul, div, conj, norm and phase on Q4.11 operands.
// A result passes two front stages, one cell per quotient bit and CORDIC rotation,
// one rounding stage and the output register. Throughput: one item per cycle while
// the skid register is free; the cell chain and the divider bits are fully pipelined.
// A skid register behind the output register holds one result while the sink stalls.
// Reset (rst_n low, asynchronous) clears every valid bit; the payload is not reset.
module complex_fixed_point_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // func[2:0], a_re[18:3], a_im[34:19], b_re[50:35], b_im[66:51], zero pad
    input  logic [cfpa_pkg::IN_TW-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // res_re[15:0], res_im[31:16], overflow[32], div_zero[33], zero pad
    output logic [cfpa_pkg::OUT_TW-1:0]   m_axis_tdata
);
    import cfpa_pkg::*;

    logic                 en, acc, take, push;
    logic                 chain_v [NCELL+1];
    cell_t                chain_c [NCELL+1];
    logic                 d_valid;
    res_t                 d_r;
    logic                 out_v_reg, skid_v_reg;
    res_t                 out_reg, skid_reg;

    // Accept while the skid register is free
    assign en            = !skid_v_reg;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && en;

    cfpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (acc),
        .func      (func_t'(s_axis_tdata[2:0])),
        .a_re      (s_axis_tdata[3+DW-1:3]),
        .a_im      (s_axis_tdata[3+2*DW-1:3+DW]),
        .b_re      (s_axis_tdata[3+3*DW-1:3+2*DW]),
        .b_im      (s_axis_tdata[3+4*DW-1:3+3*DW]),
        .out_valid (chain_v[0]),
        .out_c     (chain_c[0])
    );

    // Row of cells: a quotient bit per cell, a CORDIC rotation in the first STEPS cells
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        cfpa_cell #(.IDX(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_v[k]),
            .in_c      (chain_c[k]),
            .out_valid (chain_v[k+1]),
            .out_c     (chain_c[k+1])
        );
    end

    cfpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_v[NCELL]),
        .in_c      (chain_c[NCELL]),
        .out_valid (d_valid),
        .out_r     (d_r)
    );

    assign take = !out_v_reg || m_axis_tready;
    assign push = en && d_valid;

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (take)
        begin
            out_v_reg  <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end
        else if (push)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= skid_v_reg ? skid_reg : d_r;
        else if (push)
            skid_reg <= d_r;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(OUT_TW-2*DW-2){1'b0}}, out_reg.dz, out_reg.ov,
                            out_reg.res_im, out_reg.res_re};

    // The skid register only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full while output register empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_axis_tready))
        else $error("skid register filled without an output stall");

    a_div_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2*DW+1]) |-> (m_axis_tdata[2*DW:0] == '0))
        else $error("division by zero with non-zero result or overflow");

endmodule
